/* hdl/ble_pkg.sv */
// Shared types, constants and the level lookup table for the battery level estimator.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package ble_pkg;

   // Field widths
   localparam int ADC_W     = 12;
   localparam int RAW_W     = 16;
   localparam int SECS_W    = 16;
   localparam int LEVEL_W   = 7;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT  = 1'd1;

   localparam logic [CSR_W-1:0] SETTLE_RESET = 16'd90;
   localparam logic [CSR_W-1:0] ALERT_RESET  = 16'd30;

   // Averaging windows
   localparam int SAMPLE_TAPS = 5;
   localparam int LEVEL_TAPS  = 31;

   localparam int ADC_TOP   = 4095;
   localparam int PCT_FULL  = 100;
   localparam int SCALE_MAX = 'h0310;
   localparam int SCALE_MIN = 'h0222;
   localparam int LOW_CUT   = 14;

   // Running sums and their reciprocal-multiply division
   localparam int SAMPLE_SUM_W   = $clog2(SAMPLE_TAPS * ADC_TOP + 1);
   localparam int SAMPLE_SHIFT   = SAMPLE_SUM_W + $clog2(SAMPLE_TAPS);
   localparam int SAMPLE_RECIP_W = SAMPLE_SHIFT - $clog2(SAMPLE_TAPS) + 1;
   localparam int SAMPLE_RECIP   = ((2 ** SAMPLE_SHIFT) + SAMPLE_TAPS - 1) / SAMPLE_TAPS;
   localparam int SAMPLE_PROD_W  = SAMPLE_SUM_W + SAMPLE_RECIP_W;

   localparam int LEVEL_SUM_W    = $clog2(LEVEL_TAPS * PCT_FULL + 1);
   localparam int LEVEL_SHIFT    = LEVEL_SUM_W + $clog2(LEVEL_TAPS);
   localparam int LEVEL_RECIP_W  = LEVEL_SHIFT - $clog2(LEVEL_TAPS) + 1;
   localparam int LEVEL_RECIP    = ((2 ** LEVEL_SHIFT) + LEVEL_TAPS - 1) / LEVEL_TAPS;
   localparam int LEVEL_PROD_W   = LEVEL_SUM_W + LEVEL_RECIP_W;

   localparam int SCALE_SPAN  = SCALE_MAX - SCALE_MIN;
   localparam int SCALE_IDX_W = $clog2(SCALE_SPAN + 1);

   typedef logic [ADC_W-1:0]   sample_type;
   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic                     mode;
      logic signed [RAW_W-1:0]  raw_sample;
      logic                     charging;
      logic [SECS_W-1:0]        seconds_since_boot;
      logic                     shutdown_mode;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] charge_pct;
      logic [ADC_W-1:0]   filtered_adc;
      logic               low_battery_alert;
   } rsp_type;

   // Per-item side information carried down the pipeline
   typedef struct packed {
      logic              mode;
      logic              charging;
      logic [SECS_W-1:0] secs;
      logic              shutdown;
   } ctrl_type;

   // Shift control for a row of history cells
   typedef struct packed {
      logic shift_en;
   } row_ctl_type;

   typedef level_type lut_type [0:SCALE_SPAN];

   // Clamped average offset to level: two-step percent scaling, built at elaboration
   function automatic lut_type build_level_lut();
      lut_type lut;
      int      i;
      int      pct;
      for (i = 0; i <= SCALE_SPAN; i++) begin
         pct = (i * PCT_FULL) / SCALE_SPAN;
         if (pct > LOW_CUT) begin
            lut[i] = LEVEL_W'(((pct - LOW_CUT) * PCT_FULL) / (PCT_FULL - LOW_CUT));
         end else begin
            lut[i] = '0;
         end
      end
      return lut;
   endfunction

   localparam lut_type LEVEL_LUT = build_level_lut();

endpackage

`default_nettype wire

/* hdl/ble_sample_cell.sv */
// One cell of the converter sample history row: holds a clamped sample, passes it on.
// Depends on ble_pkg.
`default_nettype none

module ble_sample_cell
   import ble_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire row_ctl_type ctl,
   input  wire sample_type  sample_in,
   output sample_type       sample_out
);

   sample_type sample_ff;
   sample_type sample_in_w;

   assign sample_in_w = ctl.shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_w;
      end
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

/* hdl/ble_level_cell.sv */
// One cell of the level history row: holds a level, passes it on.
// Depends on ble_pkg.
`default_nettype none

module ble_level_cell
   import ble_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire row_ctl_type ctl,
   input  wire level_type   level_in,
   output level_type        level_out
);

   level_type level_ff;
   level_type level_in_w;

   assign level_in_w = ctl.shift_en ? level_in : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in_w;
      end
   end

   assign level_out = level_ff;

endmodule

`default_nettype wire

/* hdl/battery_level_estimator.sv */
// Battery level estimator: sample averaging, percent scaling, level averaging, hold rule.
// An accepted item passes through the stage registers p1 to p5, then the output register.
// The running sums and held level keep pace; a full stage holds while its successor stalls.
// Throughput: one item per cycle unless rsp_ready stalls the output.
// Reset: histories, sums, held level and pipeline valids clear; settle 90, alert delay 30.
// Depends on ble_pkg, ble_sample_cell and ble_level_cell.
`default_nettype none

module battery_level_estimator
   import ble_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int STAGES = 5;

   // Configuration
   logic [CSR_W-1:0] settle_ff, settle_in;
   logic [CSR_W-1:0] alert_dly_ff, alert_dly_in;

   always_comb begin
      settle_in    = settle_ff;
      alert_dly_in = alert_dly_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SETTLE: settle_in    = csr_wdata;
            CSR_ALERT:  alert_dly_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= SETTLE_RESET;
         alert_dly_ff <= ALERT_RESET;
      end else begin
         settle_ff    <= settle_in;
         alert_dly_ff <= alert_dly_in;
      end
   end

   // Pipeline flow control
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] go;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_go;
   logic              accept;
   logic              level_push;
   logic              out_load;

   always_comb begin
      out_go        = !rsp_valid_ff || rsp_ready;
      go[STAGES-1]  = !valid_ff[STAGES-1] || out_go;
      for (int k = STAGES - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
      valid_in[0] = go[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = go[k] ? valid_ff[k-1] : valid_ff[k];
      end
      rsp_valid_in = out_go ? valid_ff[STAGES-1] : rsp_valid_ff;
   end

   assign req_ready  = go[0];
   assign accept     = req_valid && go[0];
   assign level_push = valid_ff[2] && go[3];
   assign out_load   = valid_ff[STAGES-1] && out_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample history row and running sum
   sample_type              clamped;
   sample_type              sample_tap [SAMPLE_TAPS];
   row_ctl_type             sample_ctl;
   logic [SAMPLE_SUM_W-1:0] sample_sum_ff, sample_sum_in;

   always_comb begin
      priority if (req_data.raw_sample[RAW_W-1]) begin
         clamped = '0;
      end else if (req_data.raw_sample[RAW_W-2:ADC_W] != '0) begin
         clamped = ADC_W'(ADC_TOP);
      end else begin
         clamped = req_data.raw_sample[ADC_W-1:0];
      end
   end

   assign sample_ctl.shift_en = accept;

   for (genvar i = 0; i < SAMPLE_TAPS; i++) begin : g_sample_row
      if (i == 0) begin : g_head
         ble_sample_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (sample_ctl),
            .sample_in  (clamped),
            .sample_out (sample_tap[i])
         );
      end else begin : g_body
         ble_sample_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (sample_ctl),
            .sample_in  (sample_tap[i-1]),
            .sample_out (sample_tap[i])
         );
      end
   end

   // Retire the oldest sample, add the new one
   assign sample_sum_in = sample_sum_ff - SAMPLE_SUM_W'(sample_tap[SAMPLE_TAPS-1])
                          + SAMPLE_SUM_W'(clamped);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_sum_ff <= '0;
      end else if (accept) begin
         sample_sum_ff <= sample_sum_in;
      end
   end

   // Stage 1: new sample sum
   logic [SAMPLE_SUM_W-1:0] p1_sum_ff;
   ctrl_type                p1_ctrl_ff, req_ctrl;

   assign req_ctrl.mode     = req_data.mode;
   assign req_ctrl.charging = req_data.charging;
   assign req_ctrl.secs     = req_data.seconds_since_boot;
   assign req_ctrl.shutdown = req_data.shutdown_mode;

   always_ff @(posedge clock) begin
      if (go[0]) begin
         p1_sum_ff  <= sample_sum_in;
         p1_ctrl_ff <= req_ctrl;
      end
   end

   // Stage 2: average by reciprocal multiply
   logic [SAMPLE_PROD_W-1:0] avg_prod;
   sample_type               p2_avg_ff;
   ctrl_type                 p2_ctrl_ff;

   assign avg_prod = SAMPLE_PROD_W'(p1_sum_ff) * SAMPLE_PROD_W'(SAMPLE_RECIP);

   always_ff @(posedge clock) begin
      if (go[1]) begin
         p2_avg_ff  <= avg_prod[SAMPLE_SHIFT +: ADC_W];
         p2_ctrl_ff <= p1_ctrl_ff;
      end
   end

   // Stage 3: clamp to the scale window and look up the level
   logic [SCALE_IDX_W-1:0] scale_idx;
   sample_type             avg_off;
   level_type              p3_level_ff;
   sample_type             p3_avg_ff;
   ctrl_type               p3_ctrl_ff;

   assign avg_off = p2_avg_ff - ADC_W'(SCALE_MIN);

   always_comb begin
      priority if (p2_avg_ff < ADC_W'(SCALE_MIN)) begin
         scale_idx = '0;
      end else if (p2_avg_ff > ADC_W'(SCALE_MAX)) begin
         scale_idx = SCALE_IDX_W'(SCALE_SPAN);
      end else begin
         scale_idx = avg_off[SCALE_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (go[2]) begin
         p3_level_ff <= LEVEL_LUT[scale_idx];
         p3_avg_ff   <= p2_avg_ff;
         p3_ctrl_ff  <= p2_ctrl_ff;
      end
   end

   // Level history row and running sum
   level_type              level_tap [LEVEL_TAPS];
   row_ctl_type            level_ctl;
   logic [LEVEL_SUM_W-1:0] level_sum_ff, level_sum_in;

   assign level_ctl.shift_en = level_push;

   for (genvar i = 0; i < LEVEL_TAPS; i++) begin : g_level_row
      if (i == 0) begin : g_head
         ble_level_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (level_ctl),
            .level_in  (p3_level_ff),
            .level_out (level_tap[i])
         );
      end else begin : g_body
         ble_level_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (level_ctl),
            .level_in  (level_tap[i-1]),
            .level_out (level_tap[i])
         );
      end
   end

   assign level_sum_in = level_sum_ff - LEVEL_SUM_W'(level_tap[LEVEL_TAPS-1])
                         + LEVEL_SUM_W'(p3_level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_sum_ff <= '0;
      end else if (level_push) begin
         level_sum_ff <= level_sum_in;
      end
   end

   // Stage 4: new level sum
   logic [LEVEL_SUM_W-1:0] p4_lsum_ff;
   level_type              p4_level_ff;
   sample_type             p4_avg_ff;
   ctrl_type               p4_ctrl_ff;

   always_ff @(posedge clock) begin
      if (go[3]) begin
         p4_lsum_ff  <= level_sum_in;
         p4_level_ff <= p3_level_ff;
         p4_avg_ff   <= p3_avg_ff;
         p4_ctrl_ff  <= p3_ctrl_ff;
      end
   end

   // Stage 5: level mean while charging, else the level itself
   logic [LEVEL_PROD_W-1:0] mean_prod;
   level_type               p5_cand_ff;
   sample_type              p5_avg_ff;
   ctrl_type                p5_ctrl_ff;

   assign mean_prod = LEVEL_PROD_W'(p4_lsum_ff) * LEVEL_PROD_W'(LEVEL_RECIP);

   always_ff @(posedge clock) begin
      if (go[4]) begin
         p5_cand_ff <= p4_ctrl_ff.charging ? mean_prod[LEVEL_SHIFT +: LEVEL_W] : p4_level_ff;
         p5_avg_ff  <= p4_avg_ff;
         p5_ctrl_ff <= p4_ctrl_ff;
      end
   end

   // Output: hold rule and alert
   level_type held_ff, held_in;
   logic      take;
   logic      alert;
   rsp_type   rsp_ff;

   assign take = p5_ctrl_ff.mode || (p5_ctrl_ff.secs < settle_ff) || p5_ctrl_ff.charging
                 || (p5_cand_ff <= held_ff);
   assign held_in = take ? p5_cand_ff : held_ff;
   assign alert = !p5_ctrl_ff.mode && (held_in == '0) && !p5_ctrl_ff.charging
                  && !p5_ctrl_ff.shutdown && (p5_ctrl_ff.secs > alert_dly_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (out_load) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.charge_pct        <= held_in;
         rsp_ff.filtered_adc      <= p5_avg_ff;
         rsp_ff.low_battery_alert <= alert;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.charge_pct <= LEVEL_W'(PCT_FULL)))
      else $error("reported level above full scale");

   a_alert_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.low_battery_alert) |-> (rsp_data.charge_pct == '0))
      else $error("alert raised with non-empty level");

   a_fall_only: assert property (@(posedge clock) disable iff (reset)
      (out_load && !p5_ctrl_ff.mode && !p5_ctrl_ff.charging && (p5_ctrl_ff.secs >= settle_ff))
      |=> (held_ff <= $past(held_ff)))
      else $error("held level rose after settling");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      level_push |=> (level_sum_ff <= LEVEL_SUM_W'(LEVEL_TAPS * PCT_FULL)))
      else $error("level running sum out of range");

endmodule

`default_nettype wire

/* sim/tb_battery_level_estimator.sv */
// Testbench for battery_level_estimator: directed and random items over valid/ready channels,
// each result checked against an in-bench level predictor kept by a small scoreboard class.
// Depends on ble_pkg and the estimator RTL in hdl/.
`timescale 1ns / 1ps

module tb_battery_level_estimator;
   import ble_pkg::*;

   localparam logic MODE_MEASURE   = 1'b0;
   localparam logic MODE_PREFILL   = 1'b1;
   localparam int   ADC_MAX        = 4095;
   localparam int   SPAN_LO        = 546;
   localparam int   SPAN_HI        = 784;
   localparam int   EMPTY_PCT      = 14;
   localparam int   AVG_DEPTH      = 5;
   localparam int   TREND_DEPTH    = 31;
   localparam int   SETTLE_DEFAULT = 90;
   localparam int   ALERT_DEFAULT  = 30;
   localparam int   PHASE_ITEMS    = 370;
   localparam int   HOLD_CYCLES    = 150;

   class level_scoreboard;
      rsp_type     pending_q[$];
      int unsigned fail_count;
      int unsigned settle_secs;
      int unsigned alert_secs;
      int unsigned adc_window[AVG_DEPTH];
      int unsigned adc_total;
      int unsigned level_window[TREND_DEPTH];
      int unsigned level_total;
      int unsigned held;

      function new();
         fail_count  = 0;
         settle_secs = SETTLE_DEFAULT;
         alert_secs  = ALERT_DEFAULT;
         adc_total   = 0;
         level_total = 0;
         held        = 0;
         foreach (adc_window[i]) adc_window[i] = 0;
         foreach (level_window[i]) level_window[i] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         if (idx == CSR_SETTLE) begin
            settle_secs = 32'(val);
         end else if (idx == CSR_ALERT) begin
            alert_secs = 32'(val);
         end
      endfunction

      function void note_input(req_type item);
         int unsigned clamped;
         int unsigned avg;
         int unsigned scaled;
         int unsigned pct;
         int unsigned lvl;
         int unsigned cand;
         int          i;
         rsp_type     want;
         if (item.raw_sample[RAW_W-1]) begin
            clamped = 0;
         end else if (item.raw_sample > ADC_MAX) begin
            clamped = ADC_MAX;
         end else begin
            clamped = 32'(item.raw_sample[ADC_W-1:0]);
         end
         adc_total -= adc_window[0];
         for (i = 0; i < AVG_DEPTH - 1; i++) adc_window[i] = adc_window[i + 1];
         adc_window[AVG_DEPTH - 1] = clamped;
         adc_total += clamped;
         avg = adc_total / AVG_DEPTH;

         scaled = (avg < SPAN_LO) ? SPAN_LO : (avg > SPAN_HI) ? SPAN_HI : avg;
         pct    = ((scaled - SPAN_LO) * 100) / (SPAN_HI - SPAN_LO);
         lvl    = (pct > EMPTY_PCT) ? ((pct - EMPTY_PCT) * 100) / (100 - EMPTY_PCT) : 0;

         level_total -= level_window[0];
         for (i = 0; i < TREND_DEPTH - 1; i++) level_window[i] = level_window[i + 1];
         level_window[TREND_DEPTH - 1] = lvl;
         level_total += lvl;
         cand = item.charging ? level_total / TREND_DEPTH : lvl;

         // once settled and on battery, measure mode lets the level fall only
         if (item.mode == MODE_PREFILL || item.seconds_since_boot < settle_secs ||
             item.charging) begin
            held = cand;
         end else if (cand <= held) begin
            held = cand;
         end

         want.charge_pct        = LEVEL_W'(held);
         want.filtered_adc      = ADC_W'(avg);
         want.low_battery_alert = item.mode == MODE_MEASURE && held == 0 && !item.charging &&
                                  !item.shutdown_mode && item.seconds_since_boot > alert_secs;
         pending_q.push_back(want);
      endfunction

      function void flag(string msg);
         fail_count++;
         $display("%s", msg);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            flag($sformatf("%0t: result with no item outstanding, got level %0d adc %0d alert %0b",
                           $time, got.charge_pct, got.filtered_adc, got.low_battery_alert));
            return;
         end
         want = pending_q.pop_front();
         if (got.charge_pct !== want.charge_pct)
            flag($sformatf("%0t: charge_pct expected %0d, got %0d",
                           $time, want.charge_pct, got.charge_pct));
         if (got.filtered_adc !== want.filtered_adc)
            flag($sformatf("%0t: filtered_adc expected %0d, got %0d",
                           $time, want.filtered_adc, got.filtered_adc));
         if (got.low_battery_alert !== want.low_battery_alert)
            flag($sformatf("%0t: low_battery_alert expected %0b, got %0b",
                           $time, want.low_battery_alert, got.low_battery_alert));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   level_scoreboard sb = new();
   bit tx_idle_on   = 1'b1;
   bit rx_idle_on   = 1'b1;
   int hold_asks    = 0;
   int adc_target   = 650;

   battery_level_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_request(input req_type item);
      while (tx_idle_on && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(item);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic mode, input logic signed [RAW_W-1:0] raw,
                              input logic chg, input logic [SECS_W-1:0] secs,
                              input logic shut);
      req_type item;
      item.mode               = mode;
      item.raw_sample         = raw;
      item.charging           = chg;
      item.seconds_since_boot = secs;
      item.shutdown_mode      = shut;
      send_request(item);
   endtask

   // Both registers back to back with the write enable held high throughout.
   task automatic set_limits(input logic [CSR_W-1:0] settle, input logic [CSR_W-1:0] alert);
      csr_we    <= 1'b1;
      csr_index <= CSR_SETTLE;
      csr_wdata <= settle;
      @(negedge clock);
      sb.write_reg(CSR_SETTLE, settle);
      csr_index <= CSR_ALERT;
      csr_wdata <= alert;
      @(negedge clock);
      sb.write_reg(CSR_ALERT, alert);
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type     item;
      int unsigned roll;
      int          secs;
      // drift the battery voltage now and then so the level both climbs and drains
      if ($urandom_range(99) < 6) adc_target = $urandom_range(900, 420);
      item.mode          = ($urandom_range(99) < 20) ? MODE_PREFILL : MODE_MEASURE;
      item.charging      = $urandom_range(99) < 25;
      item.shutdown_mode = $urandom_range(99) < 15;
      roll = $urandom_range(99);
      if (roll < 10) begin
         item.raw_sample = RAW_W'($urandom_range(16'hFFFF));
      end else if (roll < 16) begin
         case ($urandom_range(5))
            0:       item.raw_sample = 16'sh8000;
            1:       item.raw_sample = 16'shFFFF;
            2:       item.raw_sample = 16'sd0;
            3:       item.raw_sample = 16'sd4095;
            4:       item.raw_sample = 16'sd4096;
            default: item.raw_sample = 16'sh7FFF;
         endcase
      end else begin
         item.raw_sample = RAW_W'(adc_target + int'($urandom_range(40)) - 20);
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
         secs = $urandom_range(65535);
      end else if (roll < 65) begin
         secs = int'(sb.settle_secs) + int'($urandom_range(6)) - 3;
      end else if (roll < 90) begin
         secs = int'(sb.alert_secs) + int'($urandom_range(6)) - 3;
      end else begin
         secs = $urandom_range(1) ? 65535 : 0;
      end
      if (secs < 0) secs = 0;
      if (secs > 65535) secs = 65535;
      item.seconds_since_boot = SECS_W'(secs);
      return item;
   endfunction

   task automatic run_directed();
      int k;
      // clamping at both ends of the raw range
      send_fields(MODE_MEASURE, 16'sh8000, 1'b0, 16'd0, 1'b0);
      send_fields(MODE_MEASURE, 16'shFFFF, 1'b0, 16'd0, 1'b0);
      send_fields(MODE_MEASURE, 16'sd0, 1'b0, 16'd0, 1'b0);
      send_fields(MODE_MEASURE, 16'sd4096, 1'b0, 16'hFFFF, 1'b0);
      send_fields(MODE_MEASURE, 16'sh7FFF, 1'b0, 16'hFFFF, 1'b1);
      // prefill to full scale, then hold it in measure mode
      for (k = 0; k < 5; k++) send_fields(MODE_PREFILL, 16'sd784, 1'b0, 16'hFFFF, 1'b0);
      send_fields(MODE_MEASURE, 16'sd4095, 1'b0, 16'hFFFF, 1'b0);
      // drain across the settle boundary
      for (k = 0; k < 5; k++)
         send_fields(MODE_MEASURE, 16'sd546, 1'b0, (k < 2) ? 16'd89 : 16'd90, 1'b0);
      send_fields(MODE_MEASURE, 16'sd700, 1'b0, 16'd90, 1'b0);
      send_fields(MODE_MEASURE, 16'sd700, 1'b0, 16'd89, 1'b0);
      // empty battery around the alert delay, then the alert blockers
      send_fields(MODE_MEASURE, 16'sd0, 1'b0, 16'd30, 1'b0);
      send_fields(MODE_MEASURE, 16'sd0, 1'b0, 16'd31, 1'b0);
      send_fields(MODE_MEASURE, 16'sd0, 1'b0, 16'd31, 1'b1);
      send_fields(MODE_MEASURE, 16'sd0, 1'b1, 16'd31, 1'b0);
      send_fields(MODE_PREFILL, 16'sd0, 1'b0, 16'd31, 1'b0);
      send_fields(MODE_MEASURE, 16'shAAAA, 1'b0, 16'hAAAA, 1'b0);
      send_fields(MODE_MEASURE, 16'sh5555, 1'b1, 16'h5555, 1'b1);
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] settle, input logic [CSR_W-1:0] alert,
                            input bit with_hold, input bit quiet_start);
      int n;
      // registers change only once the pipeline has drained
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      set_limits(settle, alert);
      @(negedge clock);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (quiet_start && n == 0) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         if (quiet_start && n == PHASE_ITEMS / 2) begin
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
         end
         if (with_hold && n == PHASE_ITEMS / 3) hold_asks++;
         send_request(random_request());
      end
      req_valid <= 1'b0;
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_done;
      int hold_left;
      hold_done = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rx_idle_on && $urandom_range(99) < 20);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(16'd0, 16'd0, 1'b1, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      run_phase(CSR_W'($urandom_range(3000, 20)), CSR_W'($urandom_range(3000, 20)),
                1'b0, 1'b1);
      run_phase(CSR_W'($urandom_range(65535)), CSR_W'($urandom_range(65535)), 1'b0, 1'b0);
      run_phase(CSR_W'(SETTLE_DEFAULT), CSR_W'(ALERT_DEFAULT), 1'b1, 1'b0);
      while (sb.pending_q.size() != 0) @(negedge clock);
      // let any stray result surface
      repeat (20) @(negedge clock);
      if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
